@@ rtl/hlr_pkg.sv @@
// ----------------------------------------------------------------------------
// hlr_pkg
// Shared types and constants for the largest-rectangle histogram block.
// ----------------------------------------------------------------------------
package hlr_pkg;

  localparam int AREA_BITS = 26;
  localparam logic [AREA_BITS-1:0] AREA_MAX = '1;

  // Control from the sequencer to the shared multiply/compare unit
  typedef struct packed {
    logic mul;  // register height * span
    logic acc;  // fold the registered product into the running maximum
    logic clr;  // start a new histogram
  } hlr_area_ctl_t;

endpackage

@@ rtl/hlr_ram.sv @@
// ----------------------------------------------------------------------------
// hlr_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module hlr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                             clk,
  input  logic                             we,
  input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] waddr,
  input  logic [WIDTH-1:0]                 wdata,
  input  logic                             re,
  input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] raddr,
  output logic [WIDTH-1:0]                 rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

@@ rtl/hlr_area.sv @@
// ----------------------------------------------------------------------------
// hlr_area
// Shared area unit: one registered multiply, then saturate and keep the max.
// ----------------------------------------------------------------------------
module hlr_area #(
  parameter int HW = 16,
  parameter int CW = 11
) (
  input  logic                           clk,
  input  logic                           rst,
  input  hlr_pkg::hlr_area_ctl_t         ctl,
  input  logic [HW-1:0]                  bar_h,
  input  logic [CW-1:0]                  span,
  output logic [hlr_pkg::AREA_BITS-1:0]  best
);
  import hlr_pkg::*;

  localparam int PW = HW + CW;
  localparam int EW = (PW > AREA_BITS) ? PW : AREA_BITS;

  logic [PW-1:0]        prod;
  logic [EW-1:0]        prod_ext;
  logic [AREA_BITS-1:0] area;

  always_ff @(posedge clk) begin
    if (ctl.mul) begin
      prod <= PW'(bar_h) * PW'(span);
    end
  end

  assign prod_ext = EW'(prod);
  // clamp to the result width
  assign area = (prod_ext > EW'(AREA_MAX)) ? AREA_MAX : prod_ext[AREA_BITS-1:0];

  always_ff @(posedge clk) begin
    if (rst || ctl.clr) begin
      best <= '0;
    end else if (ctl.acc && (area > best)) begin
      best <= area;
    end
  end

endmodule

@@ rtl/histogram_largest_rectangle.sv @@
// ----------------------------------------------------------------------------
// histogram_largest_rectangle
// Largest rectangle in a histogram with a monotonic (index, height) stack.
// Each bar pops entries of equal or greater height, then is pushed; a pop reads
// any entry below, multiplies and folds the max; the final bar drains and emits.
// Each pop is bound by the single stack RAM read port and the shared multiply.
// Synchronous reset returns to idle with an empty stack and zero counts.
// ----------------------------------------------------------------------------
module histogram_largest_rectangle #(
  parameter int MAX_BARS    = 1024,
  parameter int HEIGHT_BITS = 16
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           start,
  output logic                           busy,
  input  logic [15:0]                    height,
  input  logic                           last_bar,
  output logic                           done,
  output logic [hlr_pkg::AREA_BITS-1:0]  max_area,
  output logic                           overflowed
);
  import hlr_pkg::*;

  localparam int HW = (HEIGHT_BITS < 16) ? HEIGHT_BITS : 16;
  localparam int IW = $clog2(MAX_BARS);
  localparam int CW = $clog2(MAX_BARS + 1);
  localparam int DW = IW + HW;

  typedef enum logic [2:0] {S_IDLE, S_CMP, S_POP, S_MUL, S_ACC} state_t;

  state_t               state;
  logic [HW-1:0]        h_in;
  logic                 last_in;
  logic                 draining;
  logic [CW-1:0]        depth;
  logic [CW-1:0]        bar_count;
  logic [HW-1:0]        top_h;
  logic [HW-1:0]        pop_h;
  logic [CW-1:0]        span;
  logic                 ovf;

  logic                 ram_we;
  logic [IW-1:0]        ram_waddr;
  logic [DW-1:0]        ram_wdata;
  logic                 ram_re;
  logic [IW-1:0]        ram_raddr;
  logic [DW-1:0]        ram_rdata;
  logic [IW-1:0]        rd_idx;
  logic [HW-1:0]        rd_h;
  logic                 pop;
  logic                 deep;
  logic [CW-1:0]        depth_less2;
  hlr_area_ctl_t        area_ctl;
  logic [AREA_BITS-1:0] best;

  assign busy        = (state != S_IDLE);
  assign pop         = (depth != '0) && (draining || (top_h >= h_in));
  assign deep        = (depth > CW'(1));
  assign depth_less2 = depth - CW'(2);
  assign rd_idx      = ram_rdata[DW-1:HW];
  assign rd_h        = ram_rdata[HW-1:0];

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = depth[IW-1:0];
    ram_wdata = {bar_count[IW-1:0], h_in};
    ram_re    = 1'b0;
    ram_raddr = depth_less2[IW-1:0];
    area_ctl  = '0;
    case (state)
      S_CMP: begin
        if (pop) begin
          ram_re = deep;
        end else if (draining) begin
          area_ctl.clr = 1'b1;
        end else begin
          ram_we = 1'b1;
        end
      end
      S_MUL:   area_ctl.mul = 1'b1;
      S_ACC:   area_ctl.acc = 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      depth     <= '0;
      bar_count <= '0;
      ovf       <= 1'b0;
      draining  <= 1'b0;
      done      <= 1'b0;
    end else begin
      // register the result beat strobe from the emit cycle of a drain
      done <= (state == S_CMP) && !pop && draining;
      case (state)
        S_IDLE: begin
          if (start) begin
            h_in    <= height[HW-1:0];
            last_in <= last_bar;
            if (bar_count < CW'(MAX_BARS)) begin
              state <= S_CMP;
            end else begin
              // extra bar: drop it, but still close the histogram on the last one
              ovf <= 1'b1;
              if (last_bar) begin
                draining <= 1'b1;
                state    <= S_CMP;
              end
            end
          end
        end
        S_CMP: begin
          if (pop) begin
            pop_h <= top_h;
            if (deep) begin
              state <= S_POP;
            end else begin
              span  <= bar_count;
              depth <= '0;
              state <= S_MUL;
            end
          end else if (draining) begin
            max_area   <= best;
            overflowed <= ovf;
            depth      <= '0;
            bar_count  <= '0;
            ovf        <= 1'b0;
            draining   <= 1'b0;
            state      <= S_IDLE;
          end else begin
            top_h     <= h_in;
            depth     <= depth + CW'(1);
            bar_count <= bar_count + CW'(1);
            if (last_in) begin
              draining <= 1'b1;
            end else begin
              state <= S_IDLE;
            end
          end
        end
        S_POP: begin
          // entry below the popped one bounds the span on the left
          span  <= bar_count - (CW'(rd_idx) + CW'(1));
          top_h <= rd_h;
          depth <= depth - CW'(1);
          state <= S_MUL;
        end
        S_MUL: state <= S_ACC;
        S_ACC: state <= S_CMP;
        default: state <= S_IDLE;
      endcase
    end
  end

  hlr_ram #(
    .WIDTH (DW),
    .DEPTH (MAX_BARS)
  ) u_stack (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  hlr_area #(
    .HW (HW),
    .CW (CW)
  ) u_area (
    .clk   (clk),
    .rst   (rst),
    .ctl   (area_ctl),
    .bar_h (pop_h),
    .span  (span),
    .best  (best)
  );

  a_depth_bound: assert property (@(posedge clk) disable iff (rst)
    depth <= bar_count)
    else $error("stack deeper than bar count");

  a_pop_has_below: assert property (@(posedge clk) disable iff (rst)
    (state == S_POP) |-> (depth > CW'(1)))
    else $error("read below the stack bottom");

  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> (state == S_IDLE) && (depth == '0) && (bar_count == '0))
    else $error("result beat without cleared state");

  a_done_from_drain: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(draining) && ($past(state) == S_CMP))
    else $error("result beat outside a drain");

endmodule
